// ===== rtl/lpht_pkg.sv =====
// Package for the linear-probe hash table: sizes, codes and shared types.
// No dependencies; imported by lpht_ctrl, the top level, lpht_checker and the testbench.
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
    localparam int CNT_BITS    = ADDR_BITS + 1;
    localparam int KEY_BITS    = 32;
    localparam int VALUE_BITS  = 32;
    localparam int DATA_BITS   = 32;
    localparam int STORE_BITS  = (VALUE_BITS < DATA_BITS) ? VALUE_BITS : DATA_BITS;

    localparam logic [15:0] HOME_SALT = 16'hF93A;

    localparam int IN_TDATA_BITS  = 72;
    localparam int OUT_TDATA_BITS = 40;

    localparam logic [1:0] OP_GET  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_BIND = 2'd2;

    localparam logic [2:0] ST_FOUND     = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_INSERTED  = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_INVALID   = 3'd4;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  rd_addr;
        logic                  key_we;
        logic                  val_we;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [KEY_BITS-1:0]   wr_key;
        logic [STORE_BITS-1:0] wr_val;
    } mem_req_t;

    function automatic logic [ADDR_BITS-1:0] home_slot(input logic [KEY_BITS-1:0] key);
        logic [KEY_BITS-1:0] mixed;
        mixed = key ^ KEY_BITS'(HOME_SALT);
        return mixed[ADDR_BITS-1:0];
    endfunction

endpackage

// ===== rtl/lpht_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/lpht_ctrl.sv =====
// Probe sequencer: walks slots from the home slot, compares, writes back.
// Holds slot valid bits, entry count and the result register. Uses lpht_pkg.
`timescale 1ns / 1ps

module lpht_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [1:0]                     req_opcode,
    input  logic [lpht_pkg::KEY_BITS-1:0]  req_key,
    input  logic [lpht_pkg::DATA_BITS-1:0] req_value,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [2:0]                     rsp_status,
    output logic [lpht_pkg::DATA_BITS-1:0] rsp_value,
    output lpht_pkg::mem_req_t             mem_req,
    input  logic [lpht_pkg::KEY_BITS-1:0]  key_q,
    input  logic [lpht_pkg::STORE_BITS-1:0] val_q
);

    import lpht_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PROBE = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [1:0]             op_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [STORE_BITS-1:0]  val_reg;
    logic [ADDR_BITS-1:0]   addr_reg, addr_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_BITS-1:0]    count_reg, count_next;
    logic [2:0]             res_status_reg, res_status_next;
    logic [DATA_BITS-1:0]   res_value_reg, res_value_next;
    logic                   out_valid_reg, out_valid_next;
    logic [2:0]             out_status_reg;
    logic [DATA_BITS-1:0]   out_value_reg;

    logic                   accept;
    logic                   bad_req;
    logic [KEY_BITS-1:0]    slot_key;
    logic                   slot_empty;
    logic                   slot_hit;
    logic                   load_out;

    assign req_ready  = (state_reg == S_IDLE);
    assign accept     = req_valid && req_ready;
    assign bad_req    = (req_key == '0) || (req_opcode != OP_GET && req_opcode != OP_SET
                        && req_opcode != OP_BIND);
    assign slot_key   = valid_reg[addr_reg] ? key_q : '0;
    assign slot_empty = (slot_key == '0);
    assign slot_hit   = (slot_key == key_reg);
    assign load_out   = (state_reg == S_DONE) && (!out_valid_reg || rsp_ready);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        valid_next      = valid_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        mem_req.rd_addr = addr_reg + 1'b1;
        mem_req.key_we  = 1'b0;
        mem_req.val_we  = 1'b0;
        mem_req.wr_addr = addr_reg;
        mem_req.wr_key  = key_reg;
        mem_req.wr_val  = val_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_req.rd_addr = home_slot(req_key);
                if (accept)
                begin
                    addr_next      = home_slot(req_key);
                    res_value_next = '0;
                    if (bad_req)
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_PROBE;
                    end
                end
            end
            S_PROBE:
            begin
                if (slot_empty)
                begin
                    state_next = S_DONE;
                    if (op_reg != OP_BIND)
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                    else if (count_reg == CNT_BITS'(TABLE_DEPTH - 1))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        mem_req.key_we       = 1'b1;
                        mem_req.val_we       = 1'b1;
                        valid_next[addr_reg] = 1'b1;
                        count_next           = count_reg + 1'b1;
                        res_status_next      = ST_INSERTED;
                    end
                end
                else if (slot_hit)
                begin
                    state_next      = S_DONE;
                    res_status_next = ST_FOUND;
                    if (op_reg == OP_GET)
                    begin
                        res_value_next = DATA_BITS'(val_q);
                    end
                    else
                    begin
                        mem_req.val_we = 1'b1;
                    end
                end
                else
                begin
                    addr_next = addr_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= req_opcode;
            key_reg <= req_key;
            val_reg <= req_value[STORE_BITS-1:0];
        end
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign rsp_status = out_status_reg;
    assign rsp_value  = out_value_reg;

endmodule

// ===== rtl/linear_probe_hash_table.sv =====
// Top level of the linear-probe hash table: stream ports, key and value RAMs.
// Uses lpht_pkg, lpht_ram and lpht_ctrl.
//
//   channel  | dir | tdata fields (low bit up)                 | accepted when
//   s_axis   | in  | opcode[1:0] key[33:2] value_in[65:34]     | s_tvalid & s_tready
//   m_axis   | out | status[2:0] value_out[34:3]               | m_tvalid & m_tready
//
// A request goes from idle through probe, one slot per cycle from its home
// slot (the next slot is read while the current key is compared), to done,
// where its result is loaded into the output register for m_tvalid. s_tready
// is high only in idle. Invalid requests skip the probe. Reset empties all
// slots at once (valid bits). A result waits in the output register; one more
// request can finish its probe while it waits, then the block stalls until m_tready.
`timescale 1ns / 1ps

module linear_probe_hash_table (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lpht_pkg::IN_TDATA_BITS-1:0]    s_tdata,   // opcode, key, value_in, zero pad
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lpht_pkg::OUT_TDATA_BITS-1:0]   m_tdata    // status, value_out, zero pad
);

    import lpht_pkg::*;

    mem_req_t              mem_req;
    logic [KEY_BITS-1:0]   key_q;
    logic [STORE_BITS-1:0] val_q;
    logic [2:0]            status;
    logic [DATA_BITS-1:0]  value_out;

    lpht_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (mem_req.key_we),
        .waddr (mem_req.wr_addr),
        .wdata (mem_req.wr_key),
        .raddr (mem_req.rd_addr),
        .rdata (key_q)
    );

    lpht_ram #(
        .WIDTH (STORE_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_val_ram (
        .clk   (clk),
        .we    (mem_req.val_we),
        .waddr (mem_req.wr_addr),
        .wdata (mem_req.wr_val),
        .raddr (mem_req.rd_addr),
        .rdata (val_q)
    );

    lpht_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_opcode (s_tdata[1:0]),
        .req_key    (s_tdata[33:2]),
        .req_value  (s_tdata[65:34]),
        .rsp_valid  (m_tvalid),
        .rsp_ready  (m_tready),
        .rsp_status (status),
        .rsp_value  (value_out),
        .mem_req    (mem_req),
        .key_q      (key_q),
        .val_q      (val_q)
    );

    assign m_tdata = {5'b0, value_out, status};

endmodule

// ===== rtl/lpht_checker.sv =====
// Port-level checks for linear_probe_hash_table, attached by bind.
// Uses lpht_pkg.
`timescale 1ns / 1ps

module lpht_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lpht_pkg::OUT_TDATA_BITS-1:0] m_tdata
);

    import lpht_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] == ST_FOUND || m_tdata[2:0] == ST_NOT_FOUND
            || m_tdata[2:0] == ST_INSERTED || m_tdata[2:0] == ST_FULL
            || m_tdata[2:0] == ST_INVALID) && m_tdata[39:35] == 5'b0)
        else $error("bad status code or pad bits");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2:0] != ST_FOUND |-> m_tdata[34:3] == '0)
        else $error("value returned without a hit");

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/linear_probe_hash_table_test.sv =====
// Testbench for linear_probe_hash_table: directed and random get/set/bind requests,
// checked against an in-bench model of the probed key and value tables.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 1ps

module linear_probe_hash_table_test;

    import lpht_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 300;

    typedef struct packed {
        logic [2:0]            status;
        logic [DATA_BITS-1:0]  value;
    } outcome_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    logic [KEY_BITS-1:0]   table_keys [TABLE_DEPTH];
    logic [DATA_BITS-1:0]  table_vals [TABLE_DEPTH];
    int                    table_count;
    logic [KEY_BITS-1:0]   stored_keys [$];
    outcome_t              pending_results [$];

    int src_idle_pct = 6;
    int sink_idle_pct = 85;
    int error_count = 0;
    int cycle_count = 0;

    linear_probe_hash_table DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("linear_probe_hash_table_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Walks the probe chain and applies the request to the table copy.
    function automatic outcome_t apply_request(input logic [1:0] op,
                                               input logic [KEY_BITS-1:0] key,
                                               input logic [DATA_BITS-1:0] val);
        outcome_t res;
        int       idx;
        int       slot;
        bit       hit;
        bit       done;
        res.status = ST_INVALID;
        res.value = '0;
        if (key != '0 && op != OP_RESERVED)
        begin
            idx = int'((key ^ KEY_BITS'(HOME_SALT)) % TABLE_DEPTH);
            slot = TABLE_DEPTH;
            hit = 1'b0;
            done = 1'b0;
            for (int n = 0; n < TABLE_DEPTH && !done; n++)
            begin
                if (table_keys[idx] == '0)
                begin
                    slot = idx;
                    done = 1'b1;
                end
                else if (table_keys[idx] == key)
                begin
                    slot = idx;
                    hit = 1'b1;
                    done = 1'b1;
                end
                else
                    idx = (idx + 1) % TABLE_DEPTH;
            end
            if (op == OP_GET)
            begin
                if (hit)
                begin
                    res.status = ST_FOUND;
                    res.value = table_vals[slot];
                end
                else
                    res.status = ST_NOT_FOUND;
            end
            else if (hit)
            begin
                table_vals[slot] = val;
                res.status = ST_FOUND;
            end
            else if (op == OP_SET)
                res.status = ST_NOT_FOUND;
            else if (table_count + 1 >= TABLE_DEPTH || slot >= TABLE_DEPTH)
                res.status = ST_FULL;
            else
            begin
                table_keys[slot] = key;
                table_vals[slot] = val;
                table_count++;
                stored_keys.push_back(key);
                res.status = ST_INSERTED;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] expected,
                                   input logic [31:0] actual);
        $display("mismatch on %s at cycle %0d: expected %h, got %h",
                 field, cycle_count, expected, actual);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", '0, m_tdata[31:0]);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.status)
                    report_mismatch("status", want.status, m_tdata[2:0]);
                if (m_tdata[34:3] != want.value)
                    report_mismatch("value_out", want.value, m_tdata[34:3]);
            end
        end
    end

    task automatic send_request(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                                input logic [DATA_BITS-1:0] val);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, val, key, op};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(apply_request(op, key, val));
    endtask

    // Mix of reused keys, keys clustered around the wrap point, random keys and zero.
    function automatic logic [KEY_BITS-1:0] pick_key(input int reuse_pct);
        int                   roll;
        logic [KEY_BITS-1:0]  k;
        logic [ADDR_BITS-1:0] slot;
        roll = $urandom_range(99);
        if (roll < 4)
            return '0;
        if (roll < 4 + reuse_pct && stored_keys.size() > 0)
            return stored_keys[$urandom_range(stored_keys.size() - 1)];
        k = $urandom;
        if (roll < 29 + reuse_pct)
        begin
            slot = ADDR_BITS'(TABLE_DEPTH - 8 + $urandom_range(15));
            k[ADDR_BITS-1:0] = slot ^ HOME_SALT[ADDR_BITS-1:0];
        end
        if (k == '0)
            k = 32'h8000_0000;
        return k;
    endfunction

    task automatic random_request(input int get_pct, input int set_pct, input int reuse_pct);
        logic [1:0]           op;
        logic [DATA_BITS-1:0] val;
        int                   roll;
        roll = $urandom_range(99);
        if (roll < 4)
            op = OP_RESERVED;
        else
        begin
            roll = $urandom_range(99);
            op = (roll < get_pct) ? OP_GET : (roll < get_pct + set_pct) ? OP_SET : OP_BIND;
        end
        roll = $urandom_range(99);
        val = (roll < 5) ? '0 : (roll < 10) ? '1 : DATA_BITS'($urandom);
        send_request(op, pick_key(reuse_pct), val);
    endtask

    task automatic test_invalid_requests();
        send_request(OP_GET, '0, 32'h1234_5678);
        send_request(OP_SET, '0, '1);
        send_request(OP_BIND, '0, '1);
        send_request(OP_RESERVED, 32'hDEAD_BEEF, '1);
        send_request(OP_RESERVED, '0, '0);
    endtask

    task automatic test_absent_keys();
        send_request(OP_GET, 32'hFFFF_FFFF, '0);
        send_request(OP_SET, 32'h0000_0001, 32'hCAFE_F00D);
    endtask

    task automatic test_insert_and_update();
        send_request(OP_BIND, 32'h0000_0001, '0);
        send_request(OP_BIND, 32'hFFFF_FFFF, '1);
        send_request(OP_GET, 32'h0000_0001, '1);
        send_request(OP_GET, 32'hFFFF_FFFF, '0);
        send_request(OP_SET, 32'h0000_0001, 32'hA5A5_5A5A);
        send_request(OP_GET, 32'h0000_0001, '0);
        send_request(OP_BIND, 32'hFFFF_FFFF, 32'h0000_1234);
        send_request(OP_GET, 32'hFFFF_FFFF, '0);
    endtask

    // Keys sharing the last home slot, so the chain wraps to slot 0.
    task automatic test_probe_wrap();
        send_request(OP_BIND, 32'h1000_00C5, 32'h1111_1111);
        send_request(OP_BIND, 32'h2000_00C5, 32'h2222_2222);
        send_request(OP_BIND, 32'h4000_00C5, 32'h4444_4444);
        send_request(OP_GET, 32'h4000_00C5, '0);
        send_request(OP_SET, 32'h2000_00C5, 32'h5555_AAAA);
        send_request(OP_GET, 32'h2000_00C5, '0);
        send_request(OP_GET, 32'h8000_00C5, '0);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count)
            random_request(40, 25, 45);
    endtask

    // Mostly new binds until one slot is left, then traffic against a full table.
    task automatic test_fill_to_capacity(input int after_full);
        while (table_count < TABLE_DEPTH - 1)
            random_request(10, 5, 10);
        repeat (after_full)
            random_request(30, 15, 45);
    endtask

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            table_keys[i] = '0;
            table_vals[i] = '0;
        end
        table_count = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_invalid_requests();
        test_absent_keys();
        test_insert_and_update();
        test_probe_wrap();
        test_random_traffic(100);

        src_idle_pct = 85;
        sink_idle_pct = 6;
        test_random_traffic(100);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        test_fill_to_capacity(50);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("linear_probe_hash_table_test passed");
        else
            $display("linear_probe_hash_table_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
rtl/lpht_checker.sv
bench/linear_probe_hash_table_test.sv
